[design/etc1_mip_chain_layout_top_macros.svh]
// Assertion macros used by the checker file of the mip chain layout block
`ifndef ETC1_MIP_CHAIN_LAYOUT_TOP_MACROS_SVH
`define ETC1_MIP_CHAIN_LAYOUT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ETC1MC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ETC1MC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/etc1mc_pkg.sv]
// Shared types, constants and helper functions of the mip chain layout block
package etc1mc_pkg;

  localparam int MaxLevelsDef = 16;
  localparam int LvlCntW      = 5;
  localparam int DimW         = 16;
  localparam int BytesW       = 32;
  localparam int BlkW         = 15;
  localparam int IdxW         = 4;
  localparam int QDepth       = 2;

  // One request as it sits in the queue, level count already clamped
  typedef struct packed {
    logic [DimW-1:0]    width;
    logic [DimW-1:0]    height;
    logic [LvlCntW-1:0] levels;
    logic [BytesW-1:0]  total;
  } req_t;

  // Head of the request queue as the back end sees it
  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

  // 4x4 blocks on one axis, at least one
  function automatic logic [BlkW-1:0] blocks_on_axis(input logic [DimW-1:0] px);
    logic [DimW:0]   sum;
    logic [BlkW-1:0] b;
    sum = {1'b0, px} + (DimW+1)'(3);
    b   = sum[DimW:2];
    if (b == '0) begin
      b = BlkW'(1);
    end
    return b;
  endfunction

  // Halve a dimension, floor of 1
  function automatic logic [DimW-1:0] next_dim(input logic [DimW-1:0] px);
    logic [DimW-1:0] h;
    h = px >> 1;
    if (h == '0) begin
      h = DimW'(1);
    end
    return h;
  endfunction

endpackage

[design/etc1mc_front.sv]
// Front end: accept requests, clamp the level count, queue them for the walker
module etc1mc_front #(
  parameter int MaxLevels = etc1mc_pkg::MaxLevelsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [etc1mc_pkg::DimW-1:0]    base_width_i,
  input  logic [etc1mc_pkg::DimW-1:0]    base_height_i,
  input  logic [etc1mc_pkg::LvlCntW-1:0] level_count_i,
  input  logic [etc1mc_pkg::BytesW-1:0]  total_bytes_i,
  input  logic                           pop_i,
  output etc1mc_pkg::qhead_t             head_o
);

  localparam int PtrW = (etc1mc_pkg::QDepth > 1) ? $clog2(etc1mc_pkg::QDepth) : 1;
  localparam int CntW = $clog2(etc1mc_pkg::QDepth + 1);

  etc1mc_pkg::req_t             mem_q [etc1mc_pkg::QDepth];
  logic [PtrW-1:0]              wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         push, pop;
  logic [etc1mc_pkg::LvlCntW-1:0] lvl_clamped;
  etc1mc_pkg::req_t             req_in;

  // Clamp the level count to one .. MaxLevels
  always_comb begin
    lvl_clamped = level_count_i;
    if (level_count_i == '0) begin
      lvl_clamped = etc1mc_pkg::LvlCntW'(1);
    end else if (level_count_i > etc1mc_pkg::LvlCntW'(MaxLevels)) begin
      lvl_clamped = etc1mc_pkg::LvlCntW'(MaxLevels);
    end
  end

  assign req_in = '{width:  base_width_i,
                    height: base_height_i,
                    levels: lvl_clamped,
                    total:  total_bytes_i};

  assign busy = (cnt_q == CntW'(etc1mc_pkg::QDepth));
  assign push = start && !busy;
  assign pop  = pop_i && (cnt_q != '0);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(etc1mc_pkg::QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(etc1mc_pkg::QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

  assign head_o = '{valid: (cnt_q != '0), req: mem_q[rd_ptr_q]};

endmodule

[design/etc1mc_back.sv]
// Back end: walk the mip chain, one level per cycle, size stage then offset stage
module etc1mc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  etc1mc_pkg::qhead_t             head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  output logic [etc1mc_pkg::IdxW-1:0]    level_index_o,
  output logic [etc1mc_pkg::DimW-1:0]    level_width_o,
  output logic [etc1mc_pkg::DimW-1:0]    level_height_o,
  output logic [etc1mc_pkg::BytesW-1:0]  byte_offset_o,
  output logic [etc1mc_pkg::BytesW-1:0]  byte_size_o,
  output logic                           overflow_o,
  output logic                           last_o
);

  localparam int DimW   = etc1mc_pkg::DimW;
  localparam int BytesW = etc1mc_pkg::BytesW;
  localparam int BlkW   = etc1mc_pkg::BlkW;
  localparam int LvlW   = etc1mc_pkg::LvlCntW;
  localparam int IdxW   = etc1mc_pkg::IdxW;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   iss_q, iss_d;
  logic   s2_vld_q, s2_vld_d;
  logic   out_vld_q;

  // Size stage
  logic [DimW-1:0]   w_q, h_q;
  logic [LvlW-1:0]   idx1_q, lvls_q;
  logic [BytesW-1:0] total_q, off_q;

  // Offset stage
  logic [DimW-1:0]   s2_w_q, s2_h_q;
  logic [LvlW-1:0]   s2_idx_q;
  logic [BytesW-1:0] s2_size_q;
  logic              s2_last_q;

  // Result register
  logic [IdxW-1:0]   o_idx_q;
  logic [DimW-1:0]   o_w_q, o_h_q;
  logic [BytesW-1:0] o_off_q, o_size_q;
  logic              o_over_q, o_last_q;

  logic [BlkW-1:0]   bx, by;
  logic [2*BlkW-1:0] prod;
  logic [BytesW-1:0] size;
  logic [BytesW:0]   end_sum;
  logic              over, last_lvl1;
  logic              pop, emit, done, s1_fire;

  // Size of the level in the size stage: blocks across times blocks down times 8
  assign bx   = etc1mc_pkg::blocks_on_axis(w_q);
  assign by   = etc1mc_pkg::blocks_on_axis(h_q);
  assign prod = {{BlkW{1'b0}}, bx} * {{BlkW{1'b0}}, by};
  assign size = {prod[BytesW-4:0], 3'b000};

  // End check of the level in the offset stage, one bit wider so it cannot wrap
  assign end_sum = {1'b0, off_q} + {1'b0, s2_size_q};
  assign over    = end_sum > {1'b0, total_q};

  assign last_lvl1 = ((idx1_q + LvlW'(1)) == lvls_q);
  assign pop       = (state_q == StIdle) && head_i.valid;
  assign emit      = (state_q == StRun) && s2_vld_q;
  assign done      = emit && (over || s2_last_q);
  assign s1_fire   = (state_q == StRun) && iss_q && !done;
  assign pop_o     = pop;

  // Sequence control
  always_comb begin
    state_d  = state_q;
    iss_d    = iss_q;
    s2_vld_d = s2_vld_q;
    case (state_q)
      StIdle: begin
        if (pop) begin
          state_d  = StRun;
          iss_d    = 1'b1;
          s2_vld_d = 1'b0;
        end
      end
      StRun: begin
        s2_vld_d = s1_fire;
        if (s1_fire && last_lvl1) begin
          iss_d = 1'b0;
        end
        if (done) begin
          state_d  = StIdle;
          iss_d    = 1'b0;
          s2_vld_d = 1'b0;
        end
      end
      default: begin
        state_d  = StIdle;
        iss_d    = 1'b0;
        s2_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      iss_q     <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= emit;
    end
  end

  // Load a new item, advance the size stage, accumulate the offset
  always_ff @(posedge clk_i) begin
    if (pop) begin
      w_q     <= head_i.req.width;
      h_q     <= head_i.req.height;
      lvls_q  <= head_i.req.levels;
      total_q <= head_i.req.total;
      idx1_q  <= '0;
      off_q   <= '0;
    end else begin
      if (s1_fire) begin
        s2_w_q    <= w_q;
        s2_h_q    <= h_q;
        s2_idx_q  <= idx1_q;
        s2_size_q <= size;
        s2_last_q <= last_lvl1;
        w_q       <= etc1mc_pkg::next_dim(w_q);
        h_q       <= etc1mc_pkg::next_dim(h_q);
        idx1_q    <= idx1_q + LvlW'(1);
      end
      if (emit) begin
        off_q <= end_sum[BytesW-1:0];
      end
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_idx_q  <= s2_idx_q[IdxW-1:0];
      o_w_q    <= s2_w_q;
      o_h_q    <= s2_h_q;
      o_off_q  <= off_q;
      o_size_q <= s2_size_q;
      o_over_q <= over;
      o_last_q <= over || s2_last_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign level_index_o  = o_idx_q;
  assign level_width_o  = o_w_q;
  assign level_height_o = o_h_q;
  assign byte_offset_o  = o_off_q;
  assign byte_size_o    = o_size_q;
  assign overflow_o     = o_over_q;
  assign last_o         = o_last_q;

endmodule

[design/etc1_mip_chain_layout_top.sv]
// Top level of the ETC1 mip chain layout block
//
// Request channel: drive start with base_width_i, base_height_i,
// level_count_i and total_bytes_i; the item is taken at a rising edge
// where start is high and busy is low. A level count of zero means one
// level; counts above MAX_LEVELS are cut to MAX_LEVELS.
// Result channel: one item per mip level on the level_* / byte_* ports,
// marked by out_valid_o for a single cycle. The receiver cannot stall;
// results must be taken as they come. last_o marks the final item of a
// request; overflow_o (with last_o) marks a level that would end past
// total_bytes_i, after which no more levels follow.
// Timing: a request taken into an empty block passes the queue, the size
// stage, the offset stage and the result register before its first
// result appears; the rest follow one per cycle. The walker finishes a
// request before it takes the next; a two-deep request queue lets new
// requests in while it works, and busy rises only when that queue is full.
// Reset: rst_ni clears the queue and the walker; nothing is pending after.
module etc1_mip_chain_layout_top #(
  parameter int MAX_LEVELS = etc1mc_pkg::MaxLevelsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [etc1mc_pkg::DimW-1:0]    base_width_i,
  input  logic [etc1mc_pkg::DimW-1:0]    base_height_i,
  input  logic [etc1mc_pkg::LvlCntW-1:0] level_count_i,
  input  logic [etc1mc_pkg::BytesW-1:0]  total_bytes_i,
  output logic                           out_valid_o,
  output logic [etc1mc_pkg::IdxW-1:0]    level_index_o,
  output logic [etc1mc_pkg::DimW-1:0]    level_width_o,
  output logic [etc1mc_pkg::DimW-1:0]    level_height_o,
  output logic [etc1mc_pkg::BytesW-1:0]  byte_offset_o,
  output logic [etc1mc_pkg::BytesW-1:0]  byte_size_o,
  output logic                           overflow_o,
  output logic                           last_o
);

  etc1mc_pkg::qhead_t head;
  logic               pop;

  // Accept and queue requests
  etc1mc_front #(
    .MaxLevels(MAX_LEVELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .base_width_i (base_width_i),
    .base_height_i(base_height_i),
    .level_count_i(level_count_i),
    .total_bytes_i(total_bytes_i),
    .pop_i        (pop),
    .head_o       (head)
  );

  // Walk the chain
  etc1mc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .level_index_o (level_index_o),
    .level_width_o (level_width_o),
    .level_height_o(level_height_o),
    .byte_offset_o (byte_offset_o),
    .byte_size_o   (byte_size_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

endmodule

[design/etc1mc_checker.sv]
// Port-level checks of the mip chain layout block, bound to the top level
`include "etc1_mip_chain_layout_top_macros.svh"

module etc1mc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic [etc1mc_pkg::IdxW-1:0]    level_index_o,
  input logic [etc1mc_pkg::BytesW-1:0]  byte_offset_o,
  input logic [etc1mc_pkg::BytesW-1:0]  byte_size_o,
  input logic                           overflow_o,
  input logic                           last_o
);

  localparam int IdxW   = etc1mc_pkg::IdxW;
  localparam int BytesW = etc1mc_pkg::BytesW;

  logic              mid_chain;
  logic [IdxW-1:0]   idx_inc;
  logic [BytesW-1:0] off_next;

  // Expected index and offset of the following level
  assign mid_chain = out_valid_o && !last_o;
  assign idx_inc   = level_index_o + IdxW'(1);
  assign off_next  = byte_offset_o + byte_size_o;

  // An overflowing level always ends the walk
  `ETC1MC_ASSERT_IMP(a_over_last, out_valid_o && overflow_o, last_o, "overflow without last")

  // Levels of one request come in consecutive cycles
  `ETC1MC_ASSERT_NXT(a_no_gap, mid_chain, out_valid_o, "gap inside a mip chain")

  // Level index steps by one
  `ETC1MC_ASSERT_NXT(a_idx_step, mid_chain, level_index_o == $past(idx_inc), "index did not step")

  // Levels pack back to back
  `ETC1MC_ASSERT_NXT(a_offset_pack, mid_chain, byte_offset_o == $past(off_next), "offset gap")

endmodule

bind etc1_mip_chain_layout_top etc1mc_checker u_etc1mc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .level_index_o(level_index_o),
  .byte_offset_o(byte_offset_o),
  .byte_size_o  (byte_size_o),
  .overflow_o   (overflow_o),
  .last_o       (last_o)
);
